/* sv/gdd_pkg.sv */
// ============================================================================
// gdd_pkg
// Shared types, widths and calendar tables for the Gregorian date difference.
// ============================================================================
package gdd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int NUM_W   = 23;
    localparam int GAP_W   = 22;
    localparam int ORD_W   = 2;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 24;
    localparam int USER_W  = 2;

    localparam int QUOT_W  = 8;
    localparam int RECIP_W = 11;
    localparam int PROD_W  = YEAR_W + RECIP_W;
    localparam int RECIP_SHIFT = 17;
    localparam logic [RECIP_W-1:0] RECIP_100 = 11'd1310;

    typedef enum logic [ORD_W-1:0] {
        ORD_EQUAL   = 2'd0,
        ORD_LATER   = 2'd1,
        ORD_EARLIER = 2'd2
    } t_order;

    typedef struct packed {
        logic             ok;
        logic [NUM_W-1:0] num;
    } t_date_info;

    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] v;
        case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] v;
        case (m) inside
            4'd2:                   v = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: v = 5'd30;
            default:                v = 5'd31;
        endcase
        return v;
    endfunction

endpackage

/* sv/gregorian_date_difference.sv */
// ============================================================================
// gregorian_date_difference
// Day gap, ordering and validity of two Gregorian dates.
// ============================================================================
// Input stream: one word per date pair on s_axis; tdata carries day_a,
// month_a, year_a, day_b, month_b, year_b from the lowest bit up.
// Output stream: one word per input word on m_axis; tdata carries the
// absolute day gap and the order code, tuser the two validity flags.
// The gap is zero when either date is invalid; the order code compares the
// raw year, month and day fields whether or not the dates are valid.
// The input word passes through the input register, then the result
// register. Throughput: one date pair per cycle while m_axis does not
// stall; both day numbers and the gap are formed in one pass between
// the input and result registers.
// A stall on m_axis holds the result register; the input register still
// takes a word while it is empty, so s_axis_tready falls only when both
// registers hold words and m_axis_tready is low.
// Reset empties both registers; no word is lost or repeated afterwards.
// ============================================================================
module gregorian_date_difference
    import gdd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // day_a[4:0] month_a[8:5] year_a[22:9] day_b[27:23] month_b[31:28]
    // year_b[45:32], zero pad
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // day_gap[21:0] order[23:22]
    output logic [OUT_W-1:0]  m_axis_tdata,
    // first_ok[0] second_ok[1]
    output logic [USER_W-1:0] m_axis_tuser
);

    logic              r_in_vld;
    logic [IN_W-1:0]   r_in_data;
    logic              r_out_vld;
    logic [GAP_W-1:0]  r_gap;
    t_order            r_order;
    logic              r_ok_a;
    logic              r_ok_b;

    logic              out_load;
    logic              n_in_vld;
    logic              n_out_vld;
    logic [GAP_W-1:0]  n_gap;
    t_order            n_order;

    logic [DAY_W-1:0]   day_a;
    logic [MONTH_W-1:0] month_a;
    logic [YEAR_W-1:0]  year_a;
    logic [DAY_W-1:0]   day_b;
    logic [MONTH_W-1:0] month_b;
    logic [YEAR_W-1:0]  year_b;
    t_date_info         info_a;
    t_date_info         info_b;
    logic [NUM_W-1:0]   diff;

    assign out_load      = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || out_load;
    assign n_in_vld      = s_axis_tvalid || (r_in_vld && !out_load);
    assign n_out_vld     = out_load || (r_out_vld && !m_axis_tready);

    assign day_a   = r_in_data[4:0];
    assign month_a = r_in_data[8:5];
    assign year_a  = r_in_data[22:9];
    assign day_b   = r_in_data[27:23];
    assign month_b = r_in_data[31:28];
    assign year_b  = r_in_data[45:32];

    gdd_day_num u_date_a (
        .i_day   (day_a),
        .i_month (month_a),
        .i_year  (year_a),
        .o_info  (info_a)
    );

    gdd_day_num u_date_b (
        .i_day   (day_b),
        .i_month (month_b),
        .i_year  (year_b),
        .o_info  (info_b)
    );

    always_comb begin
        if (year_a != year_b) begin
            n_order = (year_a > year_b) ? ORD_LATER : ORD_EARLIER;
        end else if (month_a != month_b) begin
            n_order = (month_a > month_b) ? ORD_LATER : ORD_EARLIER;
        end else if (day_a != day_b) begin
            n_order = (day_a > day_b) ? ORD_LATER : ORD_EARLIER;
        end else begin
            n_order = ORD_EQUAL;
        end
    end

    assign diff  = (info_a.num >= info_b.num) ? info_a.num - info_b.num
                                              : info_b.num - info_a.num;
    assign n_gap = (info_a.ok && info_b.ok) ? diff[GAP_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
        end
        if (out_load) begin
            r_gap   <= n_gap;
            r_order <= n_order;
            r_ok_a  <= info_a.ok;
            r_ok_b  <= info_b.ok;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_order, r_gap};
    assign m_axis_tuser  = {r_ok_b, r_ok_a};

    a_gap_zero_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !(r_ok_a && r_ok_b) |-> r_gap == '0)
        else $error("day gap nonzero with an invalid date");

    a_gap_zero_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_order == ORD_EQUAL) |-> r_gap == '0)
        else $error("day gap nonzero for equal dates");

    a_gap_nonzero_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_ok_a && r_ok_b && (r_order != ORD_EQUAL) |-> r_gap != '0)
        else $error("zero day gap for distinct valid dates");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !r_out_vld |=> r_out_vld)
        else $error("input word not advanced to result register");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !m_axis_tready |=> r_out_vld && $stable(r_gap) && $stable(r_order))
        else $error("result changed while stalled");

endmodule

/* sv/gdd_day_num.sv */
// ============================================================================
// gdd_day_num
// Validity check and day number of one Gregorian date.
// ============================================================================
module gdd_day_num
    import gdd_pkg::*;
(
    input  logic [DAY_W-1:0]   i_day,
    input  logic [MONTH_W-1:0] i_month,
    input  logic [YEAR_W-1:0]  i_year,
    output t_date_info         o_info
);

    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] q_est;
    logic [YEAR_W-1:0] r_est;
    logic [QUOT_W-1:0] q100;
    logic [YEAR_W-1:0] rem100;
    logic              leap;
    logic [YEAR_W-1:0] prev;
    logic [QUOT_W-1:0] prev_q100;
    logic [QUOT_W-1:0] prev_q400;
    logic [NUM_W-1:0]  num;

    // year / 100 by reciprocal, estimate low by at most one
    assign prod  = PROD_W'(i_year) * PROD_W'(RECIP_100);
    assign q_est = prod[RECIP_SHIFT +: QUOT_W];
    assign r_est = i_year - YEAR_W'(q_est) * YEAR_W'(100);

    always_comb begin
        if (r_est >= YEAR_W'(100)) begin
            q100   = q_est + 8'd1;
            rem100 = r_est - YEAR_W'(100);
        end else begin
            q100   = q_est;
            rem100 = r_est;
        end
    end

    assign leap = ((i_year[1:0] == 2'd0) && (rem100 != '0)) ||
                  ((rem100 == '0) && (q100[1:0] == 2'd0));

    assign prev      = i_year - YEAR_W'(1);
    assign prev_q100 = (rem100 == '0) ? q100 - 8'd1 : q100;
    assign prev_q400 = prev_q100 >> 2;

    assign num = NUM_W'(i_day) + NUM_W'(days_before(i_month))
               + NUM_W'(prev) * NUM_W'(365) + NUM_W'(prev >> 2)
               - NUM_W'(prev_q100) + NUM_W'(prev_q400)
               + NUM_W'((i_month > 4'd2) && leap);

    assign o_info.ok  = (i_year != '0) && (i_month != '0) && (i_month <= 4'd12) &&
                        (i_day != '0) && (i_day <= month_len(i_month, leap));
    assign o_info.num = num;

endmodule

/* tb/sv/tb_gregorian_date_difference.sv */
// ============================================================================
// tb_gregorian_date_difference
// Self-checking bench for the Gregorian date difference block.
// ============================================================================
// Date pairs go in on s_axis one word at a time. An independent calendar
// model predicts the validity flags, the order code and the day gap of each
// accepted word. The predictions queue up and are compared field by field
// with the words that leave on m_axis. Directed pairs cover the calendar
// limits, the leap rule and every kind of invalid field. Random pairs follow,
// mostly valid dates with some noise, under three idling patterns.
// ============================================================================
module tb_gregorian_date_difference
    import gdd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [YEAR_W-1:0]  year_b;
        logic [MONTH_W-1:0] month_b;
        logic [DAY_W-1:0]   day_b;
        logic [YEAR_W-1:0]  year_a;
        logic [MONTH_W-1:0] month_a;
        logic [DAY_W-1:0]   day_a;
    } t_date_pair;

    typedef struct packed {
        logic               second_ok;
        logic               first_ok;
        t_order             order;
        logic [GAP_W-1:0]   day_gap;
    } t_gap_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // day_a, month_a, year_a, day_b, month_b, year_b, zero pad
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // day_gap, order
    logic [OUT_W-1:0]  m_axis_tdata;
    // first_ok, second_ok
    logic [USER_W-1:0] m_axis_tuser;

    t_gap_result       awaited_gaps[$];
    int unsigned       error_count = 0;
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_idle_pct = 0;

    gregorian_date_difference dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        case (m)
            2:           return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic bit date_valid(input int unsigned d, input int unsigned m,
                                      input int unsigned y);
        if (y == 0 || m < 1 || m > 12 || d == 0)
            return 1'b0;
        return d <= month_days(m, y);
    endfunction

    function automatic int unsigned serial_day(input int unsigned d, input int unsigned m,
                                               input int unsigned y);
        int unsigned n;
        int unsigned p;
        n = d;
        for (int unsigned k = 1; k < m; k++)
            n += month_days(k, y);
        p = y - 1;
        return n + 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic t_gap_result predict_gap(input t_date_pair w);
        t_gap_result r;
        int unsigned na;
        int unsigned nb;
        r.first_ok  = date_valid(w.day_a, w.month_a, w.year_a);
        r.second_ok = date_valid(w.day_b, w.month_b, w.year_b);
        if ({w.year_a, w.month_a, w.day_a} > {w.year_b, w.month_b, w.day_b})
            r.order = ORD_LATER;
        else if ({w.year_a, w.month_a, w.day_a} < {w.year_b, w.month_b, w.day_b})
            r.order = ORD_EARLIER;
        else
            r.order = ORD_EQUAL;
        r.day_gap = '0;
        if (r.first_ok && r.second_ok) begin
            na = serial_day(w.day_a, w.month_a, w.year_a);
            nb = serial_day(w.day_b, w.month_b, w.year_b);
            r.day_gap = GAP_W'((na >= nb) ? na - nb : nb - na);
        end
        return r;
    endfunction

    function automatic t_date_pair make_pair(input int unsigned da, input int unsigned ma,
                                             input int unsigned ya, input int unsigned db,
                                             input int unsigned mb, input int unsigned yb);
        t_date_pair w;
        w.day_a   = DAY_W'(da);
        w.month_a = MONTH_W'(ma);
        w.year_a  = YEAR_W'(ya);
        w.day_b   = DAY_W'(db);
        w.month_b = MONTH_W'(mb);
        w.year_b  = YEAR_W'(yb);
        return w;
    endfunction

    function automatic void pick_valid_date(output logic [DAY_W-1:0] d,
                                            output logic [MONTH_W-1:0] m,
                                            output logic [YEAR_W-1:0] y);
        int unsigned yy;
        int unsigned mm;
        yy = ($urandom_range(9) == 0) ? $urandom_range(16383, 1) : $urandom_range(9999, 1);
        mm = $urandom_range(12, 1);
        y  = YEAR_W'(yy);
        m  = MONTH_W'(mm);
        d  = DAY_W'($urandom_range(month_days(mm, yy), 1));
    endfunction

    // Hold the word until accepted, then queue its prediction.
    task automatic send_pair(input t_date_pair w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_W'({$urandom(), $urandom()});
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(w);
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        awaited_gaps.push_back(predict_gap(w));
    endtask

    task automatic test_boundary_dates();
        send_pair(make_pair(1, 1, 1, 1, 1, 1));
        send_pair(make_pair(1, 1, 1, 31, 12, 9999));
        send_pair(make_pair(31, 12, 9999, 1, 1, 1));
        send_pair(make_pair(1, 1, 1, 31, 12, 16383));
        send_pair(make_pair(31, 12, 16383, 1, 1, 1));
        send_pair(make_pair(31, 12, 1999, 1, 1, 2000));
        send_pair(make_pair(15, 6, 2024, 14, 6, 2024));
    endtask

    task automatic test_leap_days();
        send_pair(make_pair(29, 2, 2000, 1, 3, 2000));
        send_pair(make_pair(29, 2, 1900, 28, 2, 1900));
        send_pair(make_pair(29, 2, 2004, 29, 2, 2001));
        send_pair(make_pair(28, 2, 2100, 1, 3, 2100));
        send_pair(make_pair(1, 3, 2400, 29, 2, 2400));
        send_pair(make_pair(31, 12, 2000, 31, 12, 2001));
    endtask

    task automatic test_invalid_dates();
        send_pair(make_pair(1, 1, 0, 1, 1, 1));
        send_pair(make_pair(1, 0, 2000, 1, 1, 2000));
        send_pair(make_pair(1, 1, 2000, 1, 13, 2000));
        send_pair(make_pair(1, 15, 2000, 0, 5, 2000));
        send_pair(make_pair(0, 1, 1, 0, 1, 1));
        send_pair(make_pair(31, 4, 2023, 30, 4, 2023));
        send_pair(make_pair(31, 15, 16383, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, 31, 15, 16383));
        send_pair(make_pair(30, 2, 2000, 30, 2, 2000));
    endtask

    task automatic test_random_pairs(input int unsigned count);
        t_date_pair  w;
        int unsigned kind;
        for (int unsigned i = 0; i < count; i++) begin
            kind = $urandom_range(99);
            pick_valid_date(w.day_a, w.month_a, w.year_a);
            pick_valid_date(w.day_b, w.month_b, w.year_b);
            if (kind >= 60 && kind < 75) begin
                // same year, often same month: order decided on the low fields
                w.year_b = w.year_a;
                if ($urandom_range(1))
                    w.month_b = w.month_a;
                w.day_b = DAY_W'($urandom_range(month_days(w.month_b, w.year_b), 1));
            end else if (kind >= 75 && kind < 82) begin
                w.day_b   = w.day_a;
                w.month_b = w.month_a;
                w.year_b  = w.year_a;
            end else if (kind >= 82 && kind < 88) begin
                w.day_a   = DAY_W'($urandom_range(29, 28));
                w.month_a = MONTH_W'(2);
                w.year_a  = YEAR_W'($urandom_range(40, 1) * (($urandom_range(1)) ? 100 : 4));
            end else if (kind >= 88) begin
                w = t_date_pair'({$urandom(), $urandom()});
            end
            send_pair(w);
        end
    endtask

    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        t_gap_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_gaps.size() == 0) begin
                $error("result word with none awaited: tdata %h tuser %h",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = awaited_gaps.pop_front();
                if (m_axis_tdata[GAP_W-1:0] !== want.day_gap) begin
                    $error("day_gap: expected %0d, got %0d", want.day_gap,
                           m_axis_tdata[GAP_W-1:0]);
                    error_count++;
                end
                if (m_axis_tdata[GAP_W +: ORD_W] !== want.order) begin
                    $error("order: expected %0d, got %0d", want.order,
                           m_axis_tdata[GAP_W +: ORD_W]);
                    error_count++;
                end
                if (m_axis_tuser[0] !== want.first_ok) begin
                    $error("first_ok: expected %0b, got %0b", want.first_ok, m_axis_tuser[0]);
                    error_count++;
                end
                if (m_axis_tuser[1] !== want.second_ok) begin
                    $error("second_ok: expected %0b, got %0b", want.second_ok, m_axis_tuser[1]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 27;
        recv_idle_pct = 53;
        test_boundary_dates();
        test_leap_days();
        test_invalid_dates();
        test_random_pairs(560);
        send_idle_pct = 53;
        recv_idle_pct = 27;
        test_random_pairs(580);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_pairs(590);
        s_axis_tvalid <= 1'b0;
        while (awaited_gaps.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
